// ----- sv/polled_telemetry_sensor_responder_top_macros.svh -----
// assertion macros for the polled telemetry sensor responder
// used by polled_telemetry_sensor_responder_top; needs i_clk and i_rst_n in scope
`ifndef POLLED_TELEMETRY_SENSOR_RESPONDER_TOP_MACROS_SVH
`define POLLED_TELEMETRY_SENSOR_RESPONDER_TOP_MACROS_SVH
`ifndef SYNTH
// condition implies consequence in the same cycle
`define PTS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// condition implies consequence in the next cycle
`define PTS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PTS_ASSERT_NOW(name, ante, cons)
`define PTS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- sv/pts_pkg.sv -----
// types and constants of the polled telemetry sensor responder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;
    typedef enum logic [1:0] {
        CMD_RX      = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_SET_IDX = 2'd2,
        CMD_SET_IDS = 2'd3
    } t_cmd;

    localparam logic [7:0] POLL_START    = 8'h7E;
    localparam logic [7:0] DATA_START    = 8'h10;
    localparam logic [7:0] NULL_START    = 8'h00;
    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] ESC_XOR       = 8'h20;
    localparam logic [7:0] BYTE_ONES     = 8'hFF;
    localparam logic [16:0] ROUND_HALF   = 17'd64;
    localparam logic [2:0] LAST_BYTE_POS = 3'd7;

    typedef struct packed {
        logic [7:0]  sensor;
        logic [15:0] data_id;
        logic [7:0]  interval;
        logic [7:0]  last_poll;
        logic [7:0]  last_update;
    } t_entry;
endpackage
`default_nettype wire

// ----- sv/pts_if.sv -----
// valid/ready channel interfaces for input items and result beats
// uses pts_pkg for nothing; standalone
`timescale 1ns / 1ps
`default_nettype none
interface pts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic        rx_error;
    logic [7:0]  time_eighths;
    logic [7:0]  sensor_key;
    logic [15:0] data_id;
    logic [15:0] interval_ms;
    logic [3:0]  entry_index;
    logic [31:0] new_value;
    modport source (output valid, cmd, rx_byte, rx_error, time_eighths, sensor_key, data_id,
                    interval_ms, entry_index, new_value, input ready);
    modport sink (input valid, cmd, rx_byte, rx_error, time_eighths, sensor_key, data_id,
                  interval_ms, entry_index, new_value, output ready);
endinterface

interface pts_out_if;
    logic       valid;
    logic       ready;
    logic       reply_kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [3:0] added_index;
    logic       table_full;
    modport source (output valid, reply_kind, tx_byte, last, added_index, table_full,
                    input ready);
    modport sink (input valid, reply_kind, tx_byte, last, added_index, table_full,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/polled_telemetry_sensor_responder_top.sv -----
// a poll walks the table, a read state and a compare state per entry, then a write-back
// state, then 8 to 16 frame beats at one a cycle while the output is not stalled; adds and
// set-by-ids walk until the first match or the end of the table; one item at a time
// set-by-index and plain bytes finish in the idle state; the table memory read port sets the pace
// reset: synchronous active low, clears count, previous byte and value valid bits,
// sets the poll counter to one
`timescale 1ns / 1ps
`default_nettype none
`include "polled_telemetry_sensor_responder_top_macros.svh"
module polled_telemetry_sensor_responder_top #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pts_in_if.sink     i_in,
    pts_out_if.source  o_out
);
    import pts_pkg::*;

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_ADD   = 7'b0001000,
        S_WB    = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_REPLY = 7'b1000000
    } t_state;

    // memories
    t_entry      m_tab [TABLE_SLOTS];
    logic [31:0] m_val [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_vld, n_vld;
    t_entry      r_tab_q;
    logic [31:0] r_val_q;
    logic        r_vld_q;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [7:0]  r_rx, n_rx, r_now, n_now, r_sid, n_sid, r_iv, n_iv;
    logic [15:0] r_did, n_did;
    logic [CW-1:0] r_addr, n_addr, r_count, n_count;
    logic [7:0]  r_pc, n_pc, r_prev, n_prev, r_best, n_best, r_sum, n_sum;
    logic        r_found, n_found, r_esc, n_esc, r_fdata, n_fdata;
    logic [IW-1:0] r_sel_idx, n_sel_idx;
    t_entry      r_sel_ent, n_sel_ent;
    logic [31:0] r_sel_val, n_sel_val;
    logic [2:0]  r_bpos, n_bpos;
    logic [3:0]  r_rep_idx, n_rep_idx;
    logic        r_rep_full, n_rep_full;

    logic        r_out_valid, n_out_valid;
    logic        r_out_kind, n_out_kind, r_out_last, n_out_last, r_out_full, n_out_full;
    logic [7:0]  r_out_byte, n_out_byte;
    logic [3:0]  r_out_idx, n_out_idx;

    // write ports
    logic        tab_we, val_we;
    logic [IW-1:0] tab_wa, val_wa;
    t_entry      tab_wd;
    logic [31:0] val_wd;

    logic        accept, out_free, hit_id, hit_both, last_entry, better;
    logic [7:0]  poll_gap, elapsed, raw, cur, v_byte;
    logic [8:0]  sum_t;
    logic [16:0] iv_sum;
    logic [CW-1:0] addr_inc;
    logic [31:0] frame_val;

    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.reply_kind  = r_out_kind;
    assign o_out.tx_byte     = r_out_byte;
    assign o_out.last        = r_out_last;
    assign o_out.added_index = r_out_idx;
    assign o_out.table_full  = r_out_full;

    // table compares on the registered read data
    assign hit_id     = (r_tab_q.sensor == r_rx);
    assign hit_both   = (r_tab_q.sensor == r_sid) && (r_tab_q.data_id == r_did);
    assign poll_gap   = r_pc - r_tab_q.last_poll;
    assign better     = hit_id && (poll_gap > r_best);
    assign addr_inc   = r_addr + CW'(1);
    assign last_entry = !(addr_inc < r_count);
    assign elapsed    = r_now - r_sel_ent.last_update;
    assign iv_sum     = {1'b0, i_in.interval_ms} + ROUND_HALF;

    // frame byte at the current position
    assign frame_val = r_fdata ? r_sel_val : 32'd0;
    always_comb begin
        unique case (r_bpos)
            3'd0:    raw = r_fdata ? DATA_START : NULL_START;
            3'd1:    raw = r_sel_ent.data_id[7:0];
            3'd2:    raw = r_sel_ent.data_id[15:8];
            3'd3:    raw = frame_val[7:0];
            3'd4:    raw = frame_val[15:8];
            3'd5:    raw = frame_val[23:16];
            3'd6:    raw = frame_val[31:24];
            default: raw = BYTE_ONES - r_sum;
        endcase
    end
    assign cur   = raw;
    assign sum_t = {1'b0, r_sum} + {1'b0, raw};
    assign v_byte = cur ^ ESC_XOR;

    // sequencer
    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_rx = r_rx; n_now = r_now; n_sid = r_sid;
        n_did = r_did; n_iv = r_iv; n_addr = r_addr; n_count = r_count; n_pc = r_pc;
        n_prev = r_prev; n_best = r_best; n_found = r_found; n_sel_idx = r_sel_idx;
        n_sel_ent = r_sel_ent; n_sel_val = r_sel_val; n_bpos = r_bpos; n_sum = r_sum;
        n_esc = r_esc; n_fdata = r_fdata; n_rep_idx = r_rep_idx; n_rep_full = r_rep_full;
        n_vld = r_vld;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_kind = r_out_kind; n_out_byte = r_out_byte; n_out_last = r_out_last;
        n_out_idx = r_out_idx; n_out_full = r_out_full;
        tab_we = 1'b0; tab_wa = r_addr[IW-1:0]; tab_wd = r_tab_q;
        val_we = 1'b0; val_wa = r_addr[IW-1:0]; val_wd = 32'd0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = t_cmd'(i_in.cmd);
                    n_rx = i_in.rx_byte; n_now = i_in.time_eighths;
                    n_sid = i_in.sensor_key; n_did = i_in.data_id;
                    n_iv = iv_sum[14:7]; n_sel_val = i_in.new_value;
                    n_addr = '0; n_best = '0; n_found = 1'b0;
                    unique case (t_cmd'(i_in.cmd))
                        CMD_RX: begin
                            if (i_in.rx_error) begin
                                n_prev = '0;
                            end else begin
                                n_prev = i_in.rx_byte;
                                if (r_prev == POLL_START && r_count != '0) n_state = S_RD;
                            end
                        end
                        CMD_ADD: n_state = (r_count == '0) ? S_ADD : S_RD;
                        CMD_SET_IDX: begin
                            if (32'(i_in.entry_index) < TABLE_SLOTS) begin
                                val_we = 1'b1;
                                val_wa = IW'(i_in.entry_index);
                                val_wd = i_in.new_value;
                                n_vld[IW'(i_in.entry_index)] = 1'b1;
                            end
                        end
                        default: if (r_count != '0) n_state = S_RD;
                    endcase
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                n_addr = addr_inc;
                n_state = S_RD;
                unique case (r_cmd)
                    CMD_RX: begin
                        if (better) begin
                            n_best = poll_gap; n_found = 1'b1;
                            n_sel_idx = r_addr[IW-1:0]; n_sel_ent = r_tab_q;
                            n_sel_val = r_vld_q ? r_val_q : 32'd0;
                        end
                        if (last_entry) n_state = (better || r_found) ? S_WB : S_IDLE;
                    end
                    CMD_ADD: begin
                        if (hit_both) begin
                            tab_we = 1'b1;
                            tab_wd = r_tab_q; tab_wd.interval = r_iv;
                            n_rep_idx = 4'(r_addr); n_rep_full = 1'b0;
                            n_state = S_REPLY;
                        end else if (last_entry) begin
                            n_state = S_ADD;
                        end
                    end
                    default: begin
                        if (hit_both) begin
                            val_we = 1'b1; val_wd = r_sel_val;
                            n_vld[r_addr[IW-1:0]] = 1'b1;
                            n_state = S_IDLE;
                        end else if (last_entry) begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_ADD: begin
                n_state = S_REPLY;
                if (32'(r_count) >= TABLE_SLOTS) begin
                    n_rep_idx = '0; n_rep_full = 1'b1;
                end else begin
                    tab_we = 1'b1; tab_wa = r_count[IW-1:0];
                    tab_wd = '{sensor: r_sid, data_id: r_did, interval: r_iv,
                               last_poll: 8'd0, last_update: 8'd0};
                    n_rep_idx = 4'(r_count); n_rep_full = 1'b0;
                    n_count = r_count + CW'(1);
                end
            end
            S_WB: begin
                tab_we = 1'b1; tab_wa = r_sel_idx;
                tab_wd = r_sel_ent; tab_wd.last_poll = r_pc;
                n_fdata = !(elapsed < r_sel_ent.interval);
                if (!(elapsed < r_sel_ent.interval)) tab_wd.last_update = r_now;
                n_pc = r_pc + 8'd1;
                n_bpos = '0; n_sum = '0; n_esc = 1'b0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1; n_out_kind = 1'b0; n_out_idx = '0; n_out_full = 1'b0;
                    if (r_esc) begin
                        n_out_byte = v_byte; n_out_last = (r_bpos == LAST_BYTE_POS);
                        n_esc = 1'b0;
                    end else if (cur == POLL_START || cur == ESC_BYTE) begin
                        n_out_byte = ESC_BYTE; n_out_last = 1'b0; n_esc = 1'b1;
                    end else begin
                        n_out_byte = cur; n_out_last = (r_bpos == LAST_BYTE_POS);
                    end
                    // advance once the byte is fully out
                    if (r_esc || !(cur == POLL_START || cur == ESC_BYTE)) begin
                        n_sum = sum_t[7:0] + {7'd0, sum_t[8]};
                        n_bpos = r_bpos + 3'd1;
                        if (r_bpos == LAST_BYTE_POS) n_state = S_IDLE;
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    n_out_valid = 1'b1; n_out_kind = 1'b1; n_out_byte = '0;
                    n_out_last = 1'b1; n_out_idx = r_rep_idx; n_out_full = r_rep_full;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // table and value memories, registered read
    always_ff @(posedge i_clk) begin
        if (tab_we) m_tab[tab_wa] <= tab_wd;
        if (val_we) m_val[val_wa] <= val_wd;
        r_tab_q <= m_tab[r_addr[IW-1:0]];
        r_val_q <= m_val[r_addr[IW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_pc <= 8'd1; r_prev <= '0;
            r_vld <= '0; r_vld_q <= 1'b0; r_out_valid <= 1'b0; r_esc <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_pc <= n_pc; r_prev <= n_prev;
            r_vld <= n_vld; r_vld_q <= r_vld[r_addr[IW-1:0]];
            r_out_valid <= n_out_valid; r_esc <= n_esc;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_rx <= n_rx; r_now <= n_now; r_sid <= n_sid; r_did <= n_did;
        r_iv <= n_iv; r_addr <= n_addr; r_best <= n_best; r_found <= n_found;
        r_sel_idx <= n_sel_idx; r_sel_ent <= n_sel_ent; r_sel_val <= n_sel_val;
        r_bpos <= n_bpos; r_sum <= n_sum; r_fdata <= n_fdata;
        r_rep_idx <= n_rep_idx; r_rep_full <= n_rep_full;
        r_out_kind <= n_out_kind; r_out_byte <= n_out_byte; r_out_last <= n_out_last;
        r_out_idx <= n_out_idx; r_out_full <= n_out_full;
    end

    `PTS_ASSERT_NOW(a_count_bound, 1'b1, 32'(r_count) <= TABLE_SLOTS)
    `PTS_ASSERT_NOW(a_wb_has_pick, r_state == S_WB, r_found)
    `PTS_ASSERT_NOW(a_esc_in_frame, r_esc, r_state == S_EMIT)
    `PTS_ASSERT_NOW(a_reply_is_last, r_out_valid && r_out_kind, r_out_last)
    `PTS_ASSERT_NEXT(a_poll_bumps_pc, r_state == S_WB, r_pc == $past(r_pc) + 8'd1)
endmodule
`default_nettype wire
